>>> rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types and constants for the flock separation steering core.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int POS_WIDTH_DEF = 24;
	localparam int SPEED_W       = 23;
	localparam int OUT_W         = 24;
	localparam int SUM_W         = 40;
	localparam int MAG_W         = 30;
	localparam int SQ_W          = 61;
	localparam int NUM_W         = 59;
	localparam int QUO_W         = 64;
	localparam logic [SPEED_W-1:0] SPEED_RST = 23'd2560;
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_SQ,
		ST_DIVX,
		ST_DIVY,
		ST_ACC,
		ST_ONORM,
		ST_OSQ,
		ST_ROOT,
		ST_OMULX,
		ST_OMULY,
		ST_ODIVX,
		ST_ODIVY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

endpackage

>>> rtl/fss_div.sv
// ----------------------------------------------------------------------------
// fss_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fss_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fss_pkg::QUO_W-1:0] num,
	input  logic [fss_pkg::QUO_W-1:0] den,
	output logic                     busy,
	output logic [fss_pkg::QUO_W-1:0] quo
);
	logic [fss_pkg::QUO_W-1:0] rem_q, num_q, den_q;
	logic [6:0]                cnt_q;
	logic [fss_pkg::QUO_W:0]   trial;

	assign trial = {rem_q, num_q[fss_pkg::QUO_W-1]};
	assign busy  = (cnt_q != 7'd0);
	assign quo   = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'(fss_pkg::QUO_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= fss_pkg::QUO_W'(trial - {1'b0, den_q});
				num_q <= {num_q[fss_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[fss_pkg::QUO_W-1:0];
				num_q <= {num_q[fss_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("divider did not start");
endmodule

>>> rtl/fss_mul.sv
// ----------------------------------------------------------------------------
// fss_mul
// Shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fss_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              a,
	input  logic [31:0]              b,
	output logic                     busy,
	output logic [fss_pkg::QUO_W-1:0] prod
);
	logic [fss_pkg::QUO_W-1:0] acc_q, a_q;
	logic [31:0]               b_q;
	logic [5:0]                cnt_q;

	assign busy = (cnt_q != 6'd0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= {32'd0, a};
			b_q   <= b;
		end else if (busy) begin
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= {a_q[fss_pkg::QUO_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("multiplier did not start");
endmodule

>>> rtl/fss_sqrt.sv
// ----------------------------------------------------------------------------
// fss_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fss_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fss_pkg::QUO_W-1:0] rad,
	output logic                     busy,
	output logic [31:0]              root
);
	logic [fss_pkg::QUO_W-1:0] x_q;
	logic [33:0]               rem_q;
	logic [31:0]               res_q;
	logic [5:0]                cnt_q;
	logic [33:0]               trial, cand;

	assign busy  = (cnt_q != 6'd0);
	assign root  = res_q;
	assign trial = {rem_q[31:0], x_q[fss_pkg::QUO_W-1:fss_pkg::QUO_W-2]};
	assign cand  = {res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= rad;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy) begin
			x_q <= {x_q[fss_pkg::QUO_W-3:0], 2'b00};
			if (trial >= cand) begin
				rem_q <= trial - cand;
				res_q <= {res_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				res_q <= {res_q[30:0], 1'b0};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("root unit did not start");
endmodule

>>> rtl/flock_separation_steering_core.sv
// ----------------------------------------------------------------------------
// flock_separation_steering_core
// Boids separation steering: accumulates -30*2^24*d/|d|^2 per present neighbour
// word, normalises and scales by max_speed on the last word.
//
// channel  dir  payload
// s_axis   in   tdata: agent_x, agent_y, neighbor_x, neighbor_y, neighbor_present
//               tlast: last_neighbor
// m_axis   out  tdata: steer_x, steer_y
// cfg      in   data: max_speed
//
// A neighbour word goes through normalising shifts, two squares and two
// divisions; the last word adds normalising shifts, two squares, a root,
// two multiplies and two divisions. One word at a time; s_tready is low
// while a word is in work or a result waits. Reset clears accumulator, FSM.
// ----------------------------------------------------------------------------
module flock_separation_steering_core #(
	parameter int POS_WIDTH = fss_pkg::POS_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// agent_x, agent_y, neighbor_x, neighbor_y, neighbor_present, zero pad
	input  logic [((4*POS_WIDTH+1+7)/8)*8-1:0] s_tdata,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// steer_x, steer_y
	output logic [47:0]                  m_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fss_pkg::SPEED_W-1:0]  cfg_data
);
	localparam int DW = POS_WIDTH + 1;
	localparam int QW = fss_pkg::QUO_W;
	localparam logic [fss_pkg::SUM_W-1:0] NORM_LIM = fss_pkg::SUM_W'(1) << 30;

	fss_pkg::state_t state_q, state_d;
	logic [fss_pkg::SPEED_W-1:0] speed_q;
	logic signed [fss_pkg::SUM_W-1:0] sumx_q, sumy_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [fss_pkg::SUM_W-1:0] ax_q, ay_q;
	logic [5:0]  sh_q;
	logic        last_q;
	logic [QW-1:0] sq_q, qx_q, r_q;
	logic [31:0] m_q;
	logic [23:0] ox_q, oy_q;
	logic        phase_q;
	logic        sq2_q;

	logic mul_start, mul_busy, div_start, div_busy, root_start, root_busy;
	logic [31:0] ma, mb;
	logic [QW-1:0] mp, dn, dd, dq, sroot_rad;
	logic [31:0] sroot;

	logic s_acc;
	logic signed [DW-1:0] dx_w, dy_w;
	assign s_acc = s_tvalid && s_tready;
	assign dx_w = DW'($signed(s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]))
		- DW'($signed(s_tdata[POS_WIDTH-1:0]));
	assign dy_w = DW'($signed(s_tdata[4*POS_WIDTH-1:3*POS_WIDTH]))
		- DW'($signed(s_tdata[2*POS_WIDTH-1:POS_WIDTH]));

	fss_mul u_mul (.clk, .arst_n, .start(mul_start), .a(ma), .b(mb), .busy(mul_busy),
		.prod(mp));
	fss_div u_div (.clk, .arst_n, .start(div_start), .num(dn), .den(dd), .busy(div_busy),
		.quo(dq));
	fss_sqrt u_sqrt (.clk, .arst_n, .start(root_start), .rad(sroot_rad), .busy(root_busy),
		.root(sroot));

	// magnitudes of the sums
	logic [fss_pkg::SUM_W-1:0] msx, msy;
	assign msx = sumx_q[fss_pkg::SUM_W-1] ? fss_pkg::SUM_W'(-sumx_q) : sumx_q;
	assign msy = sumy_q[fss_pkg::SUM_W-1] ? fss_pkg::SUM_W'(-sumy_q) : sumy_q;

	logic [QW-1:0] tmag_x, tmag_y;
	assign tmag_x = qx_q >> sh_q;
	assign tmag_y = r_q >> sh_q;

	function automatic logic signed [fss_pkg::SUM_W-1:0] sat(
		input logic signed [fss_pkg::SUM_W-1:0] a, input logic [QW-1:0] m, input logic neg);
		logic signed [fss_pkg::SUM_W+1:0] t, r;
		begin
			t = (m[QW-1:fss_pkg::SUM_W] != '0) ? {2'b00, fss_pkg::SUM_MAX}
				: (fss_pkg::SUM_W+2)'(m[fss_pkg::SUM_W-1:0]);
			r = neg ? (fss_pkg::SUM_W+2)'(a) - t : (fss_pkg::SUM_W+2)'(a) + t;
			if (r > $signed({2'b00, fss_pkg::SUM_MAX})) return fss_pkg::SUM_MAX;
			if (r < $signed({2'b11, fss_pkg::SUM_MIN})) return fss_pkg::SUM_MIN;
			return r[fss_pkg::SUM_W-1:0];
		end
	endfunction

	logic [fss_pkg::SUM_W-1:0] topv;
	assign topv = (ax_q > ay_q) ? ax_q : ay_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fss_pkg::ST_IDLE:  if (s_acc) state_d = s_tdata[4*POS_WIDTH] ?
				fss_pkg::ST_NORM : (s_tlast ? fss_pkg::ST_ONORM : fss_pkg::ST_IDLE);
			fss_pkg::ST_NORM:  if (topv < NORM_LIM) state_d = fss_pkg::ST_SQ;
			fss_pkg::ST_SQ:    if (!mul_busy && phase_q && sq2_q) state_d =
				(topv == '0) ? (last_q ? fss_pkg::ST_ONORM : fss_pkg::ST_IDLE)
				: fss_pkg::ST_DIVX;
			fss_pkg::ST_DIVX:  if (!div_busy && phase_q) state_d = fss_pkg::ST_DIVY;
			fss_pkg::ST_DIVY:  if (!div_busy && phase_q) state_d = fss_pkg::ST_ACC;
			fss_pkg::ST_ACC:   state_d = last_q ? fss_pkg::ST_ONORM : fss_pkg::ST_IDLE;
			fss_pkg::ST_ONORM: if (phase_q) begin
				if (topv == '0) state_d = fss_pkg::ST_EMIT;
				else if ((topv >> 30) == fss_pkg::SUM_W'(1)) state_d = fss_pkg::ST_OSQ;
			end
			fss_pkg::ST_OSQ:   if (!mul_busy && phase_q && sq2_q) state_d = fss_pkg::ST_ROOT;
			fss_pkg::ST_ROOT:  if (!root_busy && phase_q) state_d = fss_pkg::ST_OMULX;
			fss_pkg::ST_OMULX: if (!mul_busy && phase_q) state_d = fss_pkg::ST_ODIVX;
			fss_pkg::ST_ODIVX: if (!div_busy && phase_q) state_d = fss_pkg::ST_OMULY;
			fss_pkg::ST_OMULY: if (!mul_busy && phase_q) state_d = fss_pkg::ST_ODIVY;
			fss_pkg::ST_ODIVY: if (!div_busy && phase_q) state_d = fss_pkg::ST_EMIT;
			fss_pkg::ST_EMIT:  if (m_tready) state_d = fss_pkg::ST_IDLE;
			default:           state_d = fss_pkg::ST_IDLE;
		endcase
	end

	// unit starts and operands
	always_comb begin
		mul_start = 1'b0; div_start = 1'b0; root_start = 1'b0;
		ma = '0; mb = '0; dn = '0; dd = sq_q; sroot_rad = sq_q;
		unique case (state_q)
			fss_pkg::ST_SQ, fss_pkg::ST_OSQ: begin
				mul_start = !mul_busy && !sq2_q;
				ma = phase_q ? ay_q[31:0] : ax_q[31:0];
				mb = ma;
			end
			fss_pkg::ST_DIVX:  begin div_start = !phase_q;
				dn = QW'({ax_q, 24'd0}) * QW'(30); end
			fss_pkg::ST_DIVY:  begin div_start = !phase_q;
				dn = QW'({ay_q, 24'd0}) * QW'(30); end
			fss_pkg::ST_ROOT:  root_start = !phase_q;
			fss_pkg::ST_OMULX: begin mul_start = !phase_q; ma = ax_q[31:0];
				mb = 32'(speed_q); end
			fss_pkg::ST_OMULY: begin mul_start = !phase_q; ma = ay_q[31:0];
				mb = 32'(speed_q); end
			fss_pkg::ST_ODIVX, fss_pkg::ST_ODIVY: begin div_start = !phase_q;
				dn = r_q; dd = QW'(m_q); end
			default: ;
		endcase
	end

	assign s_tready  = (state_q == fss_pkg::ST_IDLE);
	assign m_tvalid  = (state_q == fss_pkg::ST_EMIT);
	assign cfg_ready = 1'b1;
	assign m_tdata   = {oy_q, ox_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fss_pkg::ST_IDLE;
			speed_q <= fss_pkg::SPEED_RST;
			sumx_q  <= '0;
			sumy_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) speed_q <= cfg_data;
			phase_q <= (state_d == state_q) && (state_q != fss_pkg::ST_IDLE);
			if (state_q == fss_pkg::ST_ACC) begin
				sumx_q <= sat(sumx_q, tmag_x, dx_q > 0);
				sumy_q <= sat(sumy_q, tmag_y, dy_q > 0);
			end
			if (state_q == fss_pkg::ST_EMIT && m_tready) begin
				sumx_q <= '0;
				sumy_q <= '0;
			end
		end
	end

	// second square is folded in via a second multiply pass on the same unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq2_q <= 1'b0;
		else if (state_q != fss_pkg::ST_SQ && state_q != fss_pkg::ST_OSQ) sq2_q <= 1'b0;
		else if (!mul_busy && phase_q) sq2_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fss_pkg::ST_IDLE: if (s_acc) begin
				dx_q <= dx_w;
				dy_q <= dy_w;
				ax_q <= fss_pkg::SUM_W'(dx_w[DW-1] ? -dx_w : dx_w);
				ay_q <= fss_pkg::SUM_W'(dy_w[DW-1] ? -dy_w : dy_w);
				sh_q <= '0;
				last_q <= s_tlast;
			end
			fss_pkg::ST_NORM: if (topv >= NORM_LIM) begin
				ax_q <= ax_q >> 1; ay_q <= ay_q >> 1; sh_q <= sh_q + 6'd1;
			end
			fss_pkg::ST_SQ, fss_pkg::ST_OSQ: if (!mul_busy && phase_q)
				sq_q <= sq2_q ? sq_q + mp : mp;
			fss_pkg::ST_DIVX: if (!div_busy && phase_q) qx_q <= dq;
			fss_pkg::ST_DIVY: if (!div_busy && phase_q) r_q <= dq;
			fss_pkg::ST_ROOT: if (!root_busy && phase_q) m_q <= sroot;
			fss_pkg::ST_OMULX, fss_pkg::ST_OMULY: if (!mul_busy && phase_q) r_q <= mp;
			fss_pkg::ST_ODIVX: if (!div_busy && phase_q)
				ox_q <= sumx_q[fss_pkg::SUM_W-1] ? 24'(-dq) : dq[23:0];
			fss_pkg::ST_ODIVY: if (!div_busy && phase_q)
				oy_q <= sumy_q[fss_pkg::SUM_W-1] ? 24'(-dq) : dq[23:0];
			fss_pkg::ST_ONORM: if (!phase_q) begin
				ax_q <= msx; ay_q <= msy;
			end else if (topv == '0) begin
				ox_q <= '0; oy_q <= '0;
			end else if ((topv >> 31) != '0) begin
				ax_q <= ax_q >> 1; ay_q <= ay_q >> 1;
			end else if (!topv[30]) begin
				ax_q <= ax_q << 1; ay_q <= ay_q << 1;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_busy, div_busy, root_busy}))
		else $error("units overlap");
endmodule

>>> tb/sv/fss_checker.sv
// ----------------------------------------------------------------------------
// fss_checker
// Watches the input, output and configuration channels of the separation
// steering core, predicts every steering word and compares it field by field.
// ----------------------------------------------------------------------------
module fss_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [103:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [22:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [23:0] sx;
		logic [23:0] sy;
	} steer_t;

	steer_t        steer_q[$];
	logic [22:0]   speed;
	longint signed acc_x;
	longint signed acc_y;

	localparam longint signed ACC_HI = 64'sd549755813887;
	localparam longint signed ACC_LO = -64'sd549755813888;

	function automatic longint signed clip_add(longint signed a, longint signed b);
		longint signed r;
		r = a + b;
		if (r > ACC_HI) return ACC_HI;
		if (r < ACC_LO) return ACC_LO;
		return r;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic add_repulsion(longint signed dx, longint signed dy);
		longint unsigned mx, my, sq, qx, qy;
		int sh;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		sh = 0;
		while ((mx > my ? mx : my) >= (64'd1 << 30)) begin
			mx >>= 1;
			my >>= 1;
			sh++;
		end
		sq = mx * mx + my * my;
		if (sq == 0) return;
		qx = ((64'd30 << 24) * mx / sq) >> sh;
		qy = ((64'd30 << 24) * my / sq) >> sh;
		acc_x = clip_add(acc_x, dx > 0 ? -longint'(qx) : longint'(qx));
		acc_y = clip_add(acc_y, dy > 0 ? -longint'(qy) : longint'(qy));
	endtask

	task automatic emit_steer();
		longint unsigned mx, my, top, m, ox, oy;
		steer_t st;
		mx = acc_x < 0 ? -acc_x : acc_x;
		my = acc_y < 0 ? -acc_y : acc_y;
		top = mx > my ? mx : my;
		ox = 0;
		oy = 0;
		if (top != 0) begin
			while (top >= (64'd1 << 31)) begin
				mx >>= 1; my >>= 1; top >>= 1;
			end
			while (top < (64'd1 << 30)) begin
				mx <<= 1; my <<= 1; top <<= 1;
			end
			m = root_floor(mx * mx + my * my);
			ox = mx * speed / m;
			oy = my * speed / m;
		end
		st.sx = 24'(acc_x < 0 ? -ox : ox);
		st.sy = 24'(acc_y < 0 ? -oy : oy);
		steer_q.push_back(st);
		acc_x = 0;
		acc_y = 0;
	endtask

	assign pending = steer_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed = 23'd2560;
			acc_x = 0;
			acc_y = 0;
			steer_q.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				steer_t st;
				if (steer_q.size() == 0) begin
					$error("unexpected steering word %h", m_tdata);
					fail_count++;
				end else begin
					st = steer_q.pop_front();
					if (m_tdata[23:0] !== st.sx) begin
						$error("steer_x expected %h actual %h", st.sx, m_tdata[23:0]);
						fail_count++;
					end
					if (m_tdata[47:24] !== st.sy) begin
						$error("steer_y expected %h actual %h", st.sy, m_tdata[47:24]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				speed = cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tdata[96])
					add_repulsion(
						longint'($signed(s_tdata[71:48])) - longint'($signed(s_tdata[23:0])),
						longint'($signed(s_tdata[95:72])) - longint'($signed(s_tdata[47:24])));
				if (s_tlast)
					emit_steer();
			end
		end
	end
endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the separation steering core: directed neighbour lists, then
// random lists under several max_speed settings, with random stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [22:0]  cfg_data;
	int           fail_count;
	int           pending;
	int           idle_cycles;
	bit           calm;

	flock_separation_steering_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	fss_checker i_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// sink stall
	always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 30);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [23:0] rand_pos();
		case ($urandom_range(5))
			0: return 24'h7fffff;
			1: return 24'h800000;
			2: return 24'($urandom_range(511)) - 24'd256;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_word(logic [23:0] ax, logic [23:0] ay, logic [23:0] nx,
			logic [23:0] ny, logic pres, logic lst);
		if (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 30) @(posedge clk);
		end
		s_tdata  <= {7'd0, pres, ny, nx, ay, ax};
		s_tlast  <= lst;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic set_speed(logic [22:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || !s_tready) @(posedge clk);
		repeat (600) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_list();
		logic [23:0] ax, ay, nx, ny;
		int n;
		n = $urandom_range(4);
		ax = rand_pos();
		ay = rand_pos();
		for (int k = 0; k <= n; k++) begin
			nx = $urandom_range(3) == 0 ? rand_pos() : ax + 24'($urandom_range(4095)) - 24'd2048;
			ny = $urandom_range(3) == 0 ? rand_pos() : ay + 24'($urandom_range(4095)) - 24'd2048;
			if ($urandom_range(15) == 0) begin
				nx = ax;
				ny = ay;
			end
			send_word(ax, ay, nx, ny, $urandom_range(9) != 0, k == n);
		end
	endtask

	initial begin
		int sent;
		logic [22:0] speeds[4];
		speeds = '{23'd0, 23'h7fffff, 23'd1, 23'd256};
		arst_n = 0; s_tvalid = 0; s_tdata = '0; s_tlast = 0;
		m_tready = 0; cfg_valid = 0; cfg_data = '0; idle_cycles = 0; calm = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, zero distance, empty list, repeated neighbours
		send_word(24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b1);
		send_word(24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1);
		send_word(24'd0, 24'd0, 24'd1, 24'd0, 1'b1, 1'b1);
		send_word(24'd0, 24'd0, 24'd0, 24'hffffff, 1'b1, 1'b1);
		send_word(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 1'b1, 1'b1);
		send_word(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 1'b1, 1'b1);
		send_word(24'd5, 24'd5, 24'd6, 24'd5, 1'b1, 1'b0);
		send_word(24'd5, 24'd5, 24'd4, 24'd5, 1'b1, 1'b1);
		for (int k = 0; k < 8; k++)
			send_word(24'd0, 24'd0, 24'd1, 24'd1, 1'b1, k == 7);
		send_word(24'd100, 24'd200, 24'd50, 24'd300, 1'b0, 1'b0);
		send_word(24'hffffff, 24'd0, 24'h123456, 24'habcdef, 1'b1, 1'b1);
		sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) set_speed(ph == 4 ? 23'($urandom) : speeds[ph - 1]);
			calm = (ph == 2);
			for (int k = 0; k < 35; k++) begin
				random_list();
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		calm = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
